// ===== hw/rtl/timed_keypad_code_lock_assert.svh =====
// Assertion macros for the timed keypad code lock checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TIMED_KEYPAD_CODE_LOCK_ASSERT_SVH
`define TIMED_KEYPAD_CODE_LOCK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKCL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TKCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tkcl_pkg.sv =====
// Shared types and constants of the timed keypad code lock.
// Used by every RTL module of the block and by its checker.
`default_nettype none

package tkcl_pkg;

	localparam int TICK_W    = 24;
	localparam int CHAR_W    = 8;
	localparam int PULSE_W   = 12;
	localparam int MOTOR_W   = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
	localparam logic [CHAR_W-1:0] EMPTY_CH = 8'h2A;

	localparam logic [TICK_W-1:0]  RST_FEED_DELAY   = 24'd1500;
	localparam logic [CHAR_W-1:0]  RST_CODE_FIRST   = 8'h31;
	localparam logic [CHAR_W-1:0]  RST_CODE_SECOND  = 8'h32;
	localparam logic [PULSE_W-1:0] RST_SERVO_LOCK   = 12'd147;
	localparam logic [PULSE_W-1:0] RST_SERVO_UNLOCK = 12'd175;
	localparam logic [MOTOR_W-1:0] RST_MOTOR_MIN    = 10'd255;
	localparam logic [MOTOR_W-1:0] RST_MOTOR_MAX    = 10'd510;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FEED_DELAY   = 3'd0,
		CFG_CODE_FIRST   = 3'd1,
		CFG_CODE_SECOND  = 3'd2,
		CFG_SERVO_LOCK   = 3'd3,
		CFG_SERVO_UNLOCK = 3'd4,
		CFG_MOTOR_MIN    = 3'd5,
		CFG_MOTOR_MAX    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [TICK_W-1:0]  feed_delay_ticks;
		logic [CHAR_W-1:0]  code_first;
		logic [CHAR_W-1:0]  code_second;
		logic [PULSE_W-1:0] servo_lock_pulse;
		logic [PULSE_W-1:0] servo_unlock_pulse;
		logic [MOTOR_W-1:0] motor_min_pulse;
		logic [MOTOR_W-1:0] motor_max_pulse;
	} cfg_t;

	typedef struct packed {
		logic [3:0]         row_levels;
		logic [MOTOR_W-1:0] pot_sample;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         column_drive;
		logic               feed_permit;
		logic               locked;
		logic               entry_enabled;
		logic [CHAR_W-1:0]  entered_first;
		logic [CHAR_W-1:0]  entered_second;
		logic [PULSE_W-1:0] servo_pulse;
		logic               motor_on;
		logic [PULSE_W-1:0] motor_pulse;
	} out_word_t;

	// 3x4 keypad legend, row 0 on top, column 0 on the left.
	function automatic logic [CHAR_W-1:0] key_char(input logic [1:0] row,
			input logic [1:0] col);
		logic [CHAR_W-1:0] ch;
		ch = EMPTY_CH;
		unique case ({row, col})
			4'b00_00: ch = 8'h31;
			4'b00_01: ch = 8'h32;
			4'b00_10: ch = 8'h33;
			4'b01_00: ch = 8'h34;
			4'b01_01: ch = 8'h35;
			4'b01_10: ch = 8'h36;
			4'b10_00: ch = 8'h37;
			4'b10_01: ch = 8'h38;
			4'b10_10: ch = 8'h39;
			4'b11_00: ch = EMPTY_CH;
			4'b11_01: ch = 8'h30;
			4'b11_10: ch = 8'h23;
			default:  ch = EMPTY_CH;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tkcl_cfg.sv =====
// Configuration register file of the timed keypad code lock.
// Depends on tkcl_pkg for the register layout, indexes and reset values.
`default_nettype none

module tkcl_cfg import tkcl_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.feed_delay_ticks   <= RST_FEED_DELAY;
			cfg_q.code_first         <= RST_CODE_FIRST;
			cfg_q.code_second        <= RST_CODE_SECOND;
			cfg_q.servo_lock_pulse   <= RST_SERVO_LOCK;
			cfg_q.servo_unlock_pulse <= RST_SERVO_UNLOCK;
			cfg_q.motor_min_pulse    <= RST_MOTOR_MIN;
			cfg_q.motor_max_pulse    <= RST_MOTOR_MAX;
		end else if (cfg_we) begin
			// Indexes past the last register are ignored.
			unique case (cfg_idx_t'(cfg_index))
				CFG_FEED_DELAY:   cfg_q.feed_delay_ticks   <= cfg_wdata[TICK_W-1:0];
				CFG_CODE_FIRST:   cfg_q.code_first         <= cfg_wdata[CHAR_W-1:0];
				CFG_CODE_SECOND:  cfg_q.code_second        <= cfg_wdata[CHAR_W-1:0];
				CFG_SERVO_LOCK:   cfg_q.servo_lock_pulse   <= cfg_wdata[PULSE_W-1:0];
				CFG_SERVO_UNLOCK: cfg_q.servo_unlock_pulse <= cfg_wdata[PULSE_W-1:0];
				CFG_MOTOR_MIN:    cfg_q.motor_min_pulse    <= cfg_wdata[MOTOR_W-1:0];
				CFG_MOTOR_MAX:    cfg_q.motor_max_pulse    <= cfg_wdata[MOTOR_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tkcl_core.sv =====
// Per-tick update of the code lock: feed delay, lock FSM, keypad scanner, motor.
// Depends on tkcl_pkg; state advances only on a step from the top level.
`default_nettype none

module tkcl_core import tkcl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire in_word_t item,
	input  wire cfg_t  cfg,
	output out_word_t nxt
);

	typedef enum logic [1:0] {
		FP_START = 2'd0,
		FP_FEED  = 2'd1,
		FP_WAIT  = 2'd2,
		FP_FED   = 2'd3
	} feed_phase_t;

	typedef enum logic [1:0] {
		LP_INIT   = 2'd0,
		LP_LOCKED = 2'd1,
		LP_CHECK  = 2'd2,
		LP_OPEN   = 2'd3
	} lock_phase_t;

	typedef enum logic [2:0] {
		SP_COL0    = 3'd0,
		SP_COL1    = 3'd1,
		SP_COL2    = 3'd2,
		SP_TAKE    = 3'd3,
		SP_RELEASE = 3'd4
	} scan_phase_t;

	feed_phase_t        feed_phase_q, feed_phase_n;
	lock_phase_t        lock_phase_q, lock_phase_n;
	scan_phase_t        scan_phase_q, scan_phase_n;
	logic [TICK_W-1:0]  tick_count_q, tick_count_n, tick_mid;
	logic [1:0]         scan_col_q, scan_col_n, col_sel, row_sel;
	logic [CHAR_W-1:0]  buf0_q, buf0_n, buf1_q, buf1_n, ch;
	logic               lock_flag_q, lock_flag_n;
	logic [2:0]         col_reg_q, col_reg_n;
	logic [PULSE_W-1:0] motor_q, motor_n, servo;
	logic [MOTOR_W-1:0] span;
	logic [19:0]        prod;
	logic               permit, entry, key, row_found;

	function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
		return (v == TICK_MAX) ? v : v + 1'b1;
	endfunction

	always_comb begin
		// Feed delay: the tick that leaves the feed phase counts twice.
		feed_phase_n = feed_phase_q;
		unique case (feed_phase_q)
			FP_START: feed_phase_n = FP_FEED;
			FP_FEED:  feed_phase_n = FP_WAIT;
			FP_WAIT:  if (tick_count_q > cfg.feed_delay_ticks) feed_phase_n = FP_FED;
			FP_FED:   feed_phase_n = FP_FED;
		endcase
		tick_mid = (feed_phase_q == FP_FEED) ? sat_inc(tick_count_q) : tick_count_q;
		if (feed_phase_n == FP_FEED) begin
			tick_count_n = '0;
		end else if (feed_phase_n == FP_WAIT) begin
			tick_count_n = sat_inc(tick_mid);
		end else begin
			tick_count_n = tick_mid;
		end
		permit = (feed_phase_n == FP_FED);

		// Lock FSM compares the buffer as it stood before this tick's key.
		lock_phase_n = lock_phase_q;
		unique case (lock_phase_q)
			LP_INIT:   lock_phase_n = LP_LOCKED;
			LP_LOCKED: if (permit) lock_phase_n = LP_CHECK;
			LP_CHECK: begin
				if (buf0_q == cfg.code_first && buf1_q == cfg.code_second)
					lock_phase_n = LP_OPEN;
			end
			LP_OPEN:   lock_phase_n = LP_OPEN;
		endcase
		if (lock_phase_n == LP_LOCKED) begin
			lock_flag_n = 1'b1;
		end else if (lock_phase_n == LP_OPEN) begin
			lock_flag_n = 1'b0;
		end else begin
			lock_flag_n = lock_flag_q;
		end
		servo = (lock_phase_n == LP_OPEN) ? cfg.servo_unlock_pulse : cfg.servo_lock_pulse;
		entry = (lock_phase_n == LP_CHECK) || (lock_phase_n == LP_OPEN);

		// Keypad scanner.
		key = (item.row_levels != 4'hF);
		scan_phase_n = scan_phase_q;
		scan_col_n = scan_col_q;
		col_reg_n = col_reg_q;
		buf0_n = buf0_q;
		buf1_n = buf1_q;
		row_found = 1'b1;
		row_sel = 2'd0;
		ch = EMPTY_CH;
		col_sel = (scan_col_q > 2'd2) ? 2'd2 : scan_col_q;
		if (entry) begin
			unique case (scan_phase_q)
				SP_COL0: begin
					if (key) begin
						scan_col_n = 2'd0;
						scan_phase_n = SP_TAKE;
					end else begin
						scan_phase_n = SP_COL1;
					end
				end
				SP_COL1: begin
					if (key) begin
						scan_col_n = 2'd1;
						scan_phase_n = SP_TAKE;
					end else begin
						scan_phase_n = SP_COL2;
					end
				end
				SP_COL2: begin
					if (key) begin
						scan_col_n = 2'd2;
						scan_phase_n = SP_TAKE;
					end else begin
						scan_phase_n = SP_COL0;
					end
				end
				SP_TAKE: scan_phase_n = SP_RELEASE;
				SP_RELEASE: begin
					if (!key) begin
						unique case (scan_col_q)
							2'd0:    scan_phase_n = SP_COL1;
							2'd1:    scan_phase_n = SP_COL2;
							2'd2:    scan_phase_n = SP_COL0;
							default: scan_phase_n = SP_RELEASE;
						endcase
					end
				end
				default: scan_phase_n = SP_COL0;
			endcase

			// The column used for a take is the one just latched.
			col_sel = (scan_col_n > 2'd2) ? 2'd2 : scan_col_n;
			priority if (!item.row_levels[0]) row_sel = 2'd0;
			else if (!item.row_levels[1]) row_sel = 2'd1;
			else if (!item.row_levels[2]) row_sel = 2'd2;
			else if (!item.row_levels[3]) row_sel = 2'd3;
			else row_found = 1'b0;
			ch = key_char(row_sel, col_sel);

			unique case (scan_phase_n)
				SP_COL0: col_reg_n = 3'b110;
				SP_COL1: col_reg_n = 3'b101;
				SP_COL2: col_reg_n = 3'b011;
				SP_TAKE: begin
					if (row_found) begin
						// The clear key, or a key after a full buffer, starts over.
						if (ch == EMPTY_CH || buf1_q != EMPTY_CH) begin
							buf0_n = EMPTY_CH;
							buf1_n = EMPTY_CH;
						end
						if (buf0_n == EMPTY_CH) begin
							buf0_n = ch;
						end else if (buf1_n == EMPTY_CH) begin
							buf1_n = ch;
						end
					end
				end
				default: col_reg_n = col_reg_q;
			endcase
		end

		// Motor: min + span * pot / 512, held while unlocked.
		span = (cfg.motor_max_pulse >= cfg.motor_min_pulse)
			? cfg.motor_max_pulse - cfg.motor_min_pulse : '0;
		prod = 20'(span) * 20'(item.pot_sample);
		motor_n = lock_flag_n ? PULSE_W'(cfg.motor_min_pulse) + PULSE_W'(prod[19:9]) : motor_q;

		nxt.column_drive   = col_reg_n;
		nxt.feed_permit    = permit;
		nxt.locked         = lock_flag_n;
		nxt.entry_enabled  = entry;
		nxt.entered_first  = buf0_n;
		nxt.entered_second = buf1_n;
		nxt.servo_pulse    = servo;
		nxt.motor_on       = lock_flag_n;
		nxt.motor_pulse    = motor_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_phase_q <= FP_FEED;
			tick_count_q <= '0;
			lock_phase_q <= LP_INIT;
			scan_phase_q <= SP_COL0;
			scan_col_q   <= 2'd0;
			buf0_q       <= EMPTY_CH;
			buf1_q       <= EMPTY_CH;
			lock_flag_q  <= 1'b0;
			col_reg_q    <= 3'b111;
			motor_q      <= '0;
		end else if (step) begin
			feed_phase_q <= feed_phase_n;
			tick_count_q <= tick_count_n;
			lock_phase_q <= lock_phase_n;
			scan_phase_q <= scan_phase_n;
			scan_col_q   <= scan_col_n;
			buf0_q       <= buf0_n;
			buf1_q       <= buf1_n;
			lock_flag_q  <= lock_flag_n;
			col_reg_q    <= col_reg_n;
			motor_q      <= motor_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/timed_keypad_code_lock.sv =====
// Timed keypad code lock. Each input word is one scheduler tick; each tick
// yields exactly one output word. A word is captured in an input register
// and the tick update runs combinationally from there into the output
// register; the block takes one word per clock while the output side is
// not stalled. The throughput is set by the combinational update of the
// lock state, including the 10x10 motor speed multiply. Configuration must
// be written only while the block is idle; the block does not check it.
// Depends on tkcl_pkg, tkcl_cfg and tkcl_core.
`default_nettype none

module timed_keypad_code_lock import tkcl_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_word_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_word_t                 out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

	cfg_t      cfg;
	in_word_t  in_data_s1;
	logic      in_valid_s1;
	out_word_t nxt;
	out_word_t out_data_q;
	logic      out_valid_q;
	logic      adv;

	// A word moves on when the output register is empty or being emptied.
	assign adv = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = in_valid_s1 && !adv;

	tkcl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tkcl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (in_data_s1),
		.cfg    (cfg),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) in_valid_s1 <= in_valid;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) in_data_s1 <= in_data;
		if (adv) out_data_q <= nxt;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tkcl_checker.sv =====
// Port-level checker for the timed keypad code lock, bound to the top level.
// Depends on tkcl_pkg and the assertion macros in timed_keypad_code_lock_assert.svh.
`default_nettype none

`include "timed_keypad_code_lock_assert.svh"

module tkcl_checker import tkcl_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire out_word_t            out_data
);

	// A stalled result word stays on the port unchanged.
	`TKCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output word changed while stalled")

	// Once the feed permit is shown it never drops again.
	`TKCL_ASSERT_NEXT(a_permit_sticky, out_valid && !out_stall && out_data.feed_permit, !out_valid || out_data.feed_permit, "feed permit dropped")

	// Once unlocked the block stays unlocked.
	`TKCL_ASSERT_NEXT(a_unlock_sticky, out_valid && !out_stall && !out_data.locked, !out_valid || !out_data.locked, "lock engaged again after unlock")

	// Code entry only runs after the feed delay has elapsed.
	`TKCL_ASSERT_NOW(a_entry_needs_permit, out_valid && out_data.entry_enabled, out_data.feed_permit, "entry enabled without feed permit")

endmodule

bind timed_keypad_code_lock tkcl_checker u_checker (.*);

`default_nettype wire
